// File: hdl/btpc_pkg.sv
// Package: shared widths, register indexes and payload types for the compensation block.
`timescale 1ns / 1ps
`default_nettype none
package btpc_pkg;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam int RegCount = 8;
  localparam int DivW = 32;

  localparam logic [CfgIdxW-1:0] RegAc1 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAc2 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAc3 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAc4 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAc56 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegB12 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMcMd = 3'd6;
  localparam logic [CfgIdxW-1:0] RegOss = 3'd7;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [19:0] pressure_pa;
    logic divide_fault;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0] oss;
  } calib_t;
endpackage
`default_nettype wire

// File: hdl/btpc_if.sv
// Interfaces: valid/ready item channel and configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface btpc_in_if;
  logic valid;
  logic ready;
  btpc_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface btpc_out_if;
  logic valid;
  logic ready;
  btpc_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface btpc_cfg_if;
  logic valid;
  logic ready;
  logic [btpc_pkg::CfgIdxW-1:0] index;
  logic [btpc_pkg::CfgDataW-1:0] wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// File: hdl/btpc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module btpc_div #(
  parameter int W = 32,
  parameter int SW = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_vld,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic              out_vld,
  output logic [W-1:0]      quo,
  output logic [SW-1:0]     side_out
);
  logic [W-1:0] rem_r [W+1];
  logic [W-1:0] q_r [W+1];
  logic [W-1:0] d_r [W+1];
  logic [SW-1:0] s_r [W+1];
  logic [W:0] v_r;

  always_comb begin
    rem_r[0] = '0;
    q_r[0] = num;
    d_r[0] = den;
    s_r[0] = side_in;
    v_r[0] = in_vld;
  end

  genvar g;
  generate
    for (g = 0; g < W; g++) begin : g_st
      logic [W:0] trial;
      logic ge;
      assign trial = {rem_r[g], q_r[g][W-1]};
      assign ge = trial >= {1'b0, d_r[g]};
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g+1] <= 1'b0;
        end else if (en) begin
          v_r[g+1] <= v_r[g];
        end
        if (en) begin
          rem_r[g+1] <= ge ? W'(trial - {1'b0, d_r[g]}) : W'(trial);
          q_r[g+1] <= {q_r[g][W-2:0], ge};
          d_r[g+1] <= d_r[g];
          s_r[g+1] <= s_r[g];
        end
      end
    end
  endgenerate

  assign out_vld = v_r[W];
  assign quo = q_r[W];
  assign side_out = s_r[W];
endmodule
`default_nettype wire

// File: hdl/btpc_temp.sv
// Temperature front end: X1, divisor and signed-divide operand preparation.
`timescale 1ns / 1ps
`default_nettype none
module btpc_temp (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire btpc_pkg::calib_t   cal,
  input  wire logic [15:0]        ut,
  output logic signed [31:0]      x1,
  output logic [31:0]             num_mag,
  output logic [31:0]             den_mag,
  output logic                    neg,
  output logic                    dzero
);
  import btpc_pkg::*;
  logic signed [31:0] prod_r;
  logic signed [31:0] x1_r;
  logic signed [31:0] dv_r;
  logic signed [31:0] dv_nxt;
  logic signed [31:0] mcn;
  // stage 1: (ut-ac6)*ac5
  always_ff @(posedge clk) begin
    if (en) prod_r <= 32'(($signed({1'b0, ut}) - $signed({1'b0, cal.ac6}))
                        * $signed({1'b0, cal.ac5}));
  end
  assign dv_nxt = (prod_r >>> 15) + 32'(cal.md);
  // stage 2: x1 and divisor
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= prod_r >>> 15;
      dv_r <= dv_nxt;
    end
  end
  assign mcn = 32'(cal.mc) <<< 11;
  assign x1 = x1_r;
  assign num_mag = mcn[31] ? 32'(-mcn) : mcn;
  assign den_mag = dv_r[31] ? 32'(-dv_r) : dv_r;
  assign neg = mcn[31] ^ dv_r[31];
  assign dzero = dv_r == '0;
endmodule
`default_nettype wire

// File: hdl/btpc_pres.sv
// Pressure middle: B6, B3, X3, B4 and B7 from B5 through registered multiply stages.
`timescale 1ns / 1ps
`default_nettype none
module btpc_pres (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire btpc_pkg::calib_t cal,
  input  wire logic signed [31:0] b5,
  input  wire logic [23:0]      up_raw,
  output logic [31:0]           b7,
  output logic [31:0]           b4
);
  import btpc_pkg::*;
  logic signed [31:0] b6b_r, sq_r, pa_r, pb_r, pc_r, pd_r;
  logic [23:0] up1_r, up2_r, up3_r;
  logic signed [31:0] b3_r, x3_r;
  logic signed [31:0] b6, sqw, x3a, x3b, b3v;
  logic [31:0] up_sh;
  assign b6 = 32'(b5 - 32'sd4000);
  // stage a: b6^2, ac2*b6, ac3*b6
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= 32'(b6 * b6) >>> 12;
      pa_r <= 32'(32'(cal.ac2) * b6);
      pb_r <= 32'(32'(cal.ac3) * b6);
      up1_r <= up_raw;
    end
  end
  assign sqw = sq_r;
  // stage b: b2*sq, b1*sq
  always_ff @(posedge clk) begin
    if (en) begin
      pc_r <= 32'(32'(cal.b2) * sqw);
      pd_r <= 32'(32'(cal.b1) * sqw);
      b6b_r <= pa_r;
      up2_r <= up1_r;
    end
  end
  logic signed [31:0] pb2_r;
  always_ff @(posedge clk) if (en) pb2_r <= pb_r;
  assign x3a = 32'((pc_r >>> 11) + (b6b_r >>> 11));
  assign x3b = 32'((pb2_r >>> 13) + (pd_r >>> 16) + 32'sd2) >>> 2;
  logic signed [31:0] t4;
  assign t4 = 32'(32'(32'(32'(cal.ac1) * 4 + x3a) <<< cal.oss) + 32'sd2);
  assign b3v = t4 / 4;
  // stage c: b3 and x3
  always_ff @(posedge clk) begin
    if (en) begin
      b3_r <= b3v;
      x3_r <= x3b;
      up3_r <= up2_r;
    end
  end
  assign up_sh = 32'(up3_r >> (4'd8 - {2'b0, cal.oss}));
  // stage d: b4, b7
  always_ff @(posedge clk) begin
    if (en) begin
      b4 <= 32'({16'b0, cal.ac4} * 32'(x3_r + 32'sd32768)) >> 15;
      b7 <= 32'(32'(up_sh - b3_r) * (32'd50000 >> cal.oss));
    end
  end
endmodule
`default_nettype wire

// File: hdl/baro_temp_pressure_compensation.sv
// Top level: barometric sensor temperature and pressure compensation pipeline.
// Usage:
//  - in channel carries raw_temperature and raw_pressure; one item per cycle while in ready is high.
//  - out channel returns temperature_tenths, pressure_pa, divide_fault per item.
//  - cfg channel writes calibration registers by index; always ready.
//    Write it only while no item is in flight.
// From the accepting edge to out valid an item passes 2 temperature
// stages, a 32-stage pipelined divider for the temperature term, 4 multiply
// stages, a 32-stage divider for pressure, 2 correction stages and the output.
// Throughput is one item per cycle; the whole pipe advances as one and
// freezes when the output register holds an item the receiver has not taken.
// in_ready is high whenever the output slot is free or being taken.
// Reset clears all valid bits and sets the calibration registers to zero, oversampling 3.
// A zero divisor gives divide_fault with the affected outputs zeroed.
`timescale 1ns / 1ps
`default_nettype none
module baro_temp_pressure_compensation (
  input wire logic clk,
  input wire logic rst_n,
  btpc_in_if.sink in_ch,
  btpc_out_if.source out_ch,
  btpc_cfg_if.sink cfg_ch
);
  import btpc_pkg::*;
  calib_t cal_r;
  logic en;
  logic o_vld_r;
  out_item_t o_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
      cal_r.oss <= 2'd3;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        RegAc1: cal_r.ac1 <= cfg_ch.wdata[15:0];
        RegAc2: cal_r.ac2 <= cfg_ch.wdata[15:0];
        RegAc3: cal_r.ac3 <= cfg_ch.wdata[15:0];
        RegAc4: cal_r.ac4 <= cfg_ch.wdata[15:0];
        RegAc56: {cal_r.ac5, cal_r.ac6} <= cfg_ch.wdata;
        RegB12: {cal_r.b1, cal_r.b2} <= cfg_ch.wdata;
        RegMcMd: {cal_r.mc, cal_r.md} <= cfg_ch.wdata;
        RegOss: cal_r.oss <= cfg_ch.wdata[1:0];
        default: ;
      endcase
    end
  end

  assign en = !o_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // stages 1-2 temperature front
  logic [1:0] v_r;
  logic [23:0] up_a_r, up_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[0], in_ch.valid};
    if (en) begin
      up_a_r <= in_ch.data.raw_pressure;
      up_b_r <= up_a_r;
    end
  end
  logic signed [31:0] x1;
  logic [31:0] nm, dm;
  logic ng, dz;
  btpc_temp u_temp (.clk, .en, .cal(cal_r), .ut(in_ch.data.raw_temperature),
                    .x1, .num_mag(nm), .den_mag(dm), .neg(ng), .dzero(dz));

  localparam int S1 = 32 + 24 + 2;
  logic [S1-1:0] s1o;
  logic v1o;
  logic [31:0] q1;
  btpc_div #(.W(DivW), .SW(S1)) u_div_t (.clk, .rst_n, .en, .in_vld(v_r[1]),
    .num(nm), .den(dz ? 32'd1 : dm), .side_in({x1, up_b_r, ng, dz}),
    .out_vld(v1o), .quo(q1), .side_out(s1o));

  logic signed [31:0] x1d, x2, b5;
  logic [23:0] upd;
  logic ngd, dzd;
  assign {x1d, upd, ngd, dzd} = s1o;
  assign x2 = ngd ? 32'(-q1) : q1;
  assign b5 = 32'(x1d + x2);

  logic signed [31:0] b5_d;
  logic dz_d;
  logic [3:0] vp_r;
  logic signed [31:0] b5p_r [4];
  logic [3:0] dzp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= '0;
    else if (en) vp_r <= {vp_r[2:0], v1o};
    if (en) begin
      b5p_r[0] <= b5;
      for (int i = 1; i < 4; i++) b5p_r[i] <= b5p_r[i-1];
      dzp_r <= {dzp_r[2:0], dzd};
    end
  end
  logic [31:0] b7, b4;
  btpc_pres u_pres (.clk, .en, .cal(cal_r), .b5(b5), .up_raw(upd), .b7, .b4);
  // b4/b7 come out of the registered stages a to d of u_pres; align at vp_r[3]
  logic [31:0] pn, pd;
  logic b7hi, b4z;
  assign b4z = b4 == '0;
  assign b7hi = b7[31];
  assign pn = b7hi ? b7 : {b7[30:0], 1'b0};
  assign pd = b4z ? 32'd1 : b4;
  localparam int S2 = 32 + 3;
  logic [S2-1:0] s2o;
  logic v2o;
  logic [31:0] q2;
  btpc_div #(.W(DivW), .SW(S2)) u_div_p (.clk, .rst_n, .en, .in_vld(vp_r[3]),
    .num(pn), .den(pd), .side_in({b5p_r[3], b7hi, b4z, dzp_r[3]}),
    .out_vld(v2o), .quo(q2), .side_out(s2o));
  assign b5_d = s2o[34:3];
  assign dz_d = s2o[0];

  // pressure correction stages
  logic signed [31:0] p0, ps, t_full;
  assign p0 = s2o[2] ? {q2[30:0], 1'b0} : q2;
  assign ps = p0 >>> 8;
  logic signed [31:0] pq_r, pp_r, px2_r, pc1_r;
  logic [1:0] fl_r, fl2_r;
  logic signed [15:0] tt_r, tt2_r;
  logic [1:0] vc_r;
  assign t_full = 32'(b5_d + 32'sd8) >>> 4;
  logic signed [15:0] tsat;
  assign tsat = t_full > 32'sd32767 ? 16'sh7fff :
                t_full < -32'sd32768 ? 16'sh8000 : t_full[15:0];
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= '0;
    else if (en) vc_r <= {vc_r[0], v2o};
    if (en) begin
      pq_r <= 32'(ps * ps);
      px2_r <= 32'(-32'sd7357 * p0) >>> 16;
      pp_r <= p0;
      fl_r <= {s2o[1], dz_d};
      tt_r <= dz_d ? 16'sd0 : tsat;
      pc1_r <= 32'(pq_r * 32'sd3038) >>> 16;
      fl2_r <= fl_r;
      tt2_r <= tt_r;
    end
  end
  logic signed [31:0] px2b_r, ppb_r;
  always_ff @(posedge clk) if (en) begin
    px2b_r <= px2_r;
    ppb_r <= pp_r;
  end
  logic signed [31:0] pf;
  assign pf = 32'(ppb_r + (32'(pc1_r + px2b_r + 32'sd3791) >>> 4));
  logic [19:0] psat;
  assign psat = pf < 0 ? 20'd0 : pf > 32'sd1048575 ? 20'hfffff : pf[19:0];

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (en) o_vld_r <= vc_r[1];
    if (en) begin
      o_r.temperature_tenths <= tt2_r;
      o_r.pressure_pa <= (fl2_r[0] || fl2_r[1]) ? 20'd0 : psat;
      o_r.divide_fault <= fl2_r[0] || fl2_r[1];
    end
  end
  assign out_ch.valid = o_vld_r;
  assign out_ch.data = o_r;

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output lost under stall");
  a_fz: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.divide_fault |-> out_ch.data.pressure_pa == 20'd0)
    else $error("fault without zero pressure");
endmodule
`default_nettype wire
